// ===== design/atgs_pkg.sv =====
// ----------------------------------------------------------------------------
// atgs_pkg
// Types, constants and helpers shared by the tripod gait sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package atgs_pkg;

    localparam int LEGS    = 6;
    localparam int RAW_W   = 16;
    localparam int MAG_W   = 16;
    localparam int ANG_W   = 9;
    localparam int SPD_W   = 8;
    localparam int PHASE_W = 3;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 2;

    localparam int IN_TDATA_W  = LEGS * RAW_W;
    localparam int OUT_FIELD_W = LEGS * SPD_W + PHASE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // mod 360 by reciprocal: floor(mag * RECIP / 2^RECIP_SHIFT) is exact for mag <= 32768
    localparam logic [MAG_W-1:0] RECIP       = 16'd46604;
    localparam int               RECIP_SHIFT = 24;
    localparam int               QUOT_W      = 7;

    localparam logic [SPD_W-1:0] FAST_SPEED_RST   = 8'd15;
    localparam logic [SPD_W-1:0] SLOW_SPEED_RST   = 8'd7;
    localparam logic [ANG_W-1:0] STAND_ANGLE_RST  = 9'd130;
    localparam logic [ANG_W-1:0] SWITCH_ANGLE_RST = 9'd220;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FAST_SPEED   = 2'd0;
    localparam logic [IDX_W-1:0] REG_SLOW_SPEED   = 2'd1;
    localparam logic [IDX_W-1:0] REG_STAND_ANGLE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_SWITCH_ANGLE = 2'd3;

    // tripods: legs 1,3,5 and legs 2,4,6
    localparam logic [LEGS-1:0] TRI_ODD  = 6'b010101;
    localparam logic [LEGS-1:0] TRI_EVEN = 6'b101010;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_1     = 5'b00010,
        PH_2     = 5'b00100,
        PH_3     = 5'b01000,
        PH_4     = 5'b10000
    } t_phase;

    localparam logic [PHASE_W-1:0] CODE_START = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_1     = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_2     = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_3     = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_4     = 3'd4;

    typedef struct packed {
        logic [SPD_W-1:0] fast_speed;
        logic [SPD_W-1:0] slow_speed;
        logic [ANG_W-1:0] stand_angle;
        logic [ANG_W-1:0] switch_angle;
    } t_cfg;

    typedef logic [LEGS-1:0][ANG_W-1:0] t_ang_vec;
    typedef logic [LEGS-1:0][SPD_W-1:0] t_spd_vec;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_1:    code = CODE_1;
            PH_2:    code = CODE_2;
            PH_3:    code = CODE_3;
            PH_4:    code = CODE_4;
            default: code = CODE_START;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== design/atgs_reduce.sv =====
// ----------------------------------------------------------------------------
// atgs_reduce
// Reduces one signed leg angle to its magnitude modulo 360 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module atgs_reduce
    import atgs_pkg::*;
(
    input  wire logic [RAW_W-1:0] i_raw,
    output logic      [ANG_W-1:0] o_ang
);

    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] prod;
    logic [QUOT_W-1:0]  quot;
    logic [MAG_W-1:0]   sub;
    logic [MAG_W-1:0]   rem;

    // two's complement magnitude, most negative value gives 32768
    assign mag  = i_raw[RAW_W-1] ? (~i_raw + 1'b1) : i_raw;
    assign prod = mag * RECIP;
    assign quot = prod[RECIP_SHIFT +: QUOT_W];
    // quot * 360 as shifts and adds
    assign sub  = (MAG_W'(quot) << 8) + (MAG_W'(quot) << 6)
                + (MAG_W'(quot) << 5) + (MAG_W'(quot) << 3);
    assign rem  = mag - sub;
    assign o_ang = rem[ANG_W-1:0];

endmodule

`default_nettype wire

// ===== design/atgs_core.sv =====
// ----------------------------------------------------------------------------
// atgs_core
// Gait phase and done flags, with the speed command of each leg per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module atgs_core
    import atgs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire t_cfg               i_cfg,
    input  wire t_ang_vec           i_ang,
    output t_spd_vec                o_spd,
    output logic      [PHASE_W-1:0] o_phase
);

    t_phase           r_phase, n_phase;
    logic [LEGS-1:0]  r_done, n_done;
    t_phase           adv_phase;
    logic [LEGS-1:0]  group;
    logic [LEGS-1:0]  hit;
    logic [SPD_W-1:0] speed;
    logic [ANG_W-1:0] target;

    always_comb begin
        n_phase   = r_phase;
        n_done    = r_done;
        adv_phase = PH_4;
        group     = '0;
        speed     = '0;
        target    = '0;
        unique case (r_phase)
            PH_1: begin
                group     = TRI_EVEN;
                speed     = i_cfg.fast_speed;
                target    = i_cfg.stand_angle;
                adv_phase = PH_2;
            end
            PH_2: begin
                group     = TRI_ODD;
                speed     = i_cfg.slow_speed;
                target    = i_cfg.switch_angle;
                adv_phase = PH_3;
            end
            PH_3: begin
                group     = TRI_ODD;
                speed     = i_cfg.fast_speed;
                target    = i_cfg.stand_angle;
                adv_phase = PH_4;
            end
            PH_4: begin
                group     = TRI_EVEN;
                speed     = i_cfg.slow_speed;
                target    = i_cfg.switch_angle;
                adv_phase = PH_1;
            end
            default: begin
                adv_phase = PH_4;
            end
        endcase

        for (int i = 0; i < LEGS; i++) begin
            hit[i]   = (i_ang[i] == target);
            o_spd[i] = (group[i] && !hit[i]) ? speed : '0;
        end

        if (r_phase == PH_START) begin
            n_phase = PH_4;
        end else begin
            n_done = r_done | (group & hit);
            if ((n_done & group) == group) begin
                n_done  = n_done & ~group;
                n_phase = adv_phase;
            end
        end
    end

    assign o_phase = phase_code(n_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_done  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

endmodule

`default_nettype wire

// ===== design/angle_tripod_gait_sequencer.sv =====
// ----------------------------------------------------------------------------
// angle_tripod_gait_sequencer
// Tripod gait sequencer: leg angles in, leg speed commands and phase out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick of six signed 16-bit leg angles; m_axis returns
//   one result per tick with six 8-bit leg speeds and the 3-bit gait phase.
//   The configuration port writes fast/slow speed and stand/switch angle by
//   index; write it only while no transfer is in flight.
// Pipeline: input register, then result register driving m_axis_tvalid. The angle
//   reduction (magnitude mod 360 by a constant reciprocal multiply) sits in
//   front of the input register; compare and phase logic sit between the
//   input register and the result register.
// Throughput: one tick per cycle while the result is not stalled; the phase
//   state is updated in the same cycle that the result register loads.
// Reset: synchronous active low; phase returns to start, done flags clear,
//   registers return to 15, 7, 130, 220, both pipeline stages empty.
// Stall: while m_axis_tready is low the result holds; one more tick can wait
//   in the input register before s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_tripod_gait_sequencer
    import atgs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // leg1_angle..leg6_angle, 16 bits each
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // leg1_speed..leg6_speed (8 bits each), gait_phase (3 bits), zero pad
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cfg               r_cfg;
    logic               r_in_valid;
    t_ang_vec           r_ang;
    t_ang_vec           ang_red;
    logic               r_out_valid;
    t_spd_vec           r_spd;
    logic [PHASE_W-1:0] r_phase_out;
    t_spd_vec           spd;
    logic [PHASE_W-1:0] phase_out;
    logic               out_free;
    logic               step;
    logic               in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_speed   <= FAST_SPEED_RST;
            r_cfg.slow_speed   <= SLOW_SPEED_RST;
            r_cfg.stand_angle  <= STAND_ANGLE_RST;
            r_cfg.switch_angle <= SWITCH_ANGLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FAST_SPEED:   r_cfg.fast_speed   <= i_cfg_data[SPD_W-1:0];
                REG_SLOW_SPEED:   r_cfg.slow_speed   <= i_cfg_data[SPD_W-1:0];
                REG_STAND_ANGLE:  r_cfg.stand_angle  <= i_cfg_data[ANG_W-1:0];
                REG_SWITCH_ANGLE: r_cfg.switch_angle <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < LEGS; g++) begin : g_leg
        atgs_reduce u_reduce (
            .i_raw (s_axis_tdata[g*RAW_W +: RAW_W]),
            .o_ang (ang_red[g])
        );
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ang <= ang_red;
        end
    end

    atgs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (r_cfg),
        .i_ang   (r_ang),
        .o_spd   (spd),
        .o_phase (phase_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_spd       <= spd;
            r_phase_out <= phase_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), r_phase_out, r_spd};

endmodule

`default_nettype wire

// ===== design/atgs_checker.sv =====
// ----------------------------------------------------------------------------
// atgs_checker
// Port-level checks for the tripod gait sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atgs_checker
    import atgs_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // empty pipeline right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result shown right after reset");

    // phase code is start or one of the four gait phases
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[LEGS*SPD_W +: PHASE_W] <= CODE_4))
        else $error("gait phase out of range");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0))
        else $error("pad bits set");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind angle_tripod_gait_sequencer atgs_checker u_atgs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_angle_tripod_gait_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_angle_tripod_gait_sequencer
// Self-checking bench for the tripod gait sequencer. A directed table walks
// one full gait cycle with angle extremes, then random ticks are mostly
// steered to land moving legs on their target so the phase keeps advancing.
// Every output transfer is compared field by field against an in-bench
// model of the phase and done-flag state, across several register settings
// with random idling on both stream sides.
// ----------------------------------------------------------------------------

module tb_angle_tripod_gait_sequencer;

    import atgs_pkg::*;

    localparam int RES_W     = LEGS * SPD_W + PHASE_W;
    localparam int HALF_CLK  = 5;
    localparam int N_CONFIGS = 9;
    localparam int N_TICKS   = 170;
    localparam int N_PLAN    = 8;

    // gait_phase above the six speeds, leg1 speed in the lowest bits
    typedef struct packed {
        logic [PHASE_W-1:0]         ph;
        logic [LEGS-1:0][SPD_W-1:0] spd;
    } t_gait_result;

    typedef struct packed {
        logic [LEGS-1:0][RAW_W-1:0] ang;
        logic                       fixed;
        t_gait_result               res;
    } t_tick_row;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [IDX_W-1:0]       i_cfg_idx      = '0;
    logic [CFG_W-1:0]       i_cfg_data     = '0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow of the block state and registers
    logic [PHASE_W-1:0] gait_phase_q = CODE_START;
    logic [LEGS-1:0]    leg_done_q   = '0;
    logic [SPD_W-1:0]   cfg_fast     = FAST_SPEED_RST;
    logic [SPD_W-1:0]   cfg_slow     = SLOW_SPEED_RST;
    logic [ANG_W-1:0]   cfg_stand    = STAND_ANGLE_RST;
    logic [ANG_W-1:0]   cfg_switch   = SWITCH_ANGLE_RST;

    t_gait_result pending_results[$];
    t_tick_row    plan [N_PLAN];
    int           mismatches  = 0;
    bit           burst       = 1'b0;
    bit           rx_hold_req = 1'b0;

    angle_tripod_gait_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // leg1_angle..leg6_angle, 16 bits each
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // leg1_speed..leg6_speed, gait_phase, pad
    );

    always #(HALF_CLK) i_clk = ~i_clk;

    function automatic int fold_angle(input logic [RAW_W-1:0] v);
        int mag;
        mag = v[RAW_W-1] ? 65536 - int'(v) : int'(v);
        return mag % 360;
    endfunction

    function automatic t_gait_result advance_gait(input logic [LEGS-1:0][RAW_W-1:0] ang);
        t_gait_result     r;
        logic [LEGS-1:0]  movers;
        logic [SPD_W-1:0] speed;
        logic [ANG_W-1:0] target;
        r.spd = '0;
        if (gait_phase_q >= CODE_1 && gait_phase_q <= CODE_4) begin
            movers = (gait_phase_q == CODE_1 || gait_phase_q == CODE_4) ? TRI_EVEN : TRI_ODD;
            if (gait_phase_q == CODE_1 || gait_phase_q == CODE_3) begin
                speed  = cfg_fast;
                target = cfg_stand;
            end else begin
                speed  = cfg_slow;
                target = cfg_switch;
            end
            for (int i = 0; i < LEGS; i++) begin
                if (movers[i]) begin
                    if (fold_angle(ang[i]) == int'(target))
                        leg_done_q[i] = 1'b1;
                    else
                        r.spd[i] = speed;
                end
            end
            if ((leg_done_q & movers) == movers) begin
                leg_done_q   = leg_done_q & ~movers;
                gait_phase_q = (gait_phase_q == CODE_4) ? CODE_1 : gait_phase_q + 1'b1;
            end
        end else begin
            gait_phase_q = CODE_4;
        end
        r.ph = gait_phase_q;
        return r;
    endfunction

    // mostly steer moving legs onto the target so the gait keeps cycling
    function automatic logic [LEGS-1:0][RAW_W-1:0] pick_tick();
        logic [LEGS-1:0][RAW_W-1:0] ang;
        logic [LEGS-1:0]            movers;
        logic [ANG_W-1:0]           target;
        int                         mag;
        bit                         noise;
        noise  = ($urandom_range(0, 99) < 15);
        movers = (gait_phase_q == CODE_1 || gait_phase_q == CODE_4) ? TRI_EVEN : TRI_ODD;
        target = (gait_phase_q == CODE_1 || gait_phase_q == CODE_3) ? cfg_stand : cfg_switch;
        for (int i = 0; i < LEGS; i++) begin
            if (!noise && target < 360 &&
                $urandom_range(0, 99) < (movers[i] ? 40 : 15)) begin
                mag = int'(target) + 360 * int'($urandom_range(0, (32768 - target) / 360));
                ang[i] = (mag == 32768 || $urandom_range(0, 1)) ? RAW_W'(-mag) : RAW_W'(mag);
            end else begin
                case ($urandom_range(0, noise ? 3 : 1))
                    0: ang[i] = RAW_W'($urandom);
                    1: begin
                        mag = $urandom_range(0, 719);
                        ang[i] = $urandom_range(0, 1) ? RAW_W'(-mag) : RAW_W'(mag);
                    end
                    2: ang[i] = 16'h8000;
                    default: ang[i] = 16'h7fff;
                endcase
            end
        end
        return ang;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic offer_tick(input logic [LEGS-1:0][RAW_W-1:0] ang, input logic fixed,
                              input t_gait_result fixed_res);
        int           gap;
        t_gait_result r;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= ang;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        r = advance_gait(ang);
        pending_results = {pending_results, (fixed ? fixed_res : r)};
    endtask

    task automatic poke(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_FAST_SPEED:   cfg_fast   = val[SPD_W-1:0];
            REG_SLOW_SPEED:   cfg_slow   = val[SPD_W-1:0];
            REG_STAND_ANGLE:  cfg_stand  = val[ANG_W-1:0];
            REG_SWITCH_ANGLE: cfg_switch = val[ANG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input int f, input int s, input int st, input int sw);
        poke(REG_FAST_SPEED, CFG_W'(f));
        poke(REG_SLOW_SPEED, CFG_W'(s));
        poke(REG_STAND_ANGLE, CFG_W'(st));
        poke(REG_SWITCH_ANGLE, CFG_W'(sw));
        i_cfg_we <= 1'b0;
    endtask

    // stop offering, then wait until every expected result has come
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // receiver side
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end
            gap = burst ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_gait_result want;
        t_gait_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result, phase", got.ph, 0);
            end else begin
                want = pending_results.pop_front();
                for (int i = 0; i < LEGS; i++)
                    if (got.spd[i] !== want.spd[i])
                        note_mismatch($sformatf("leg%0d_speed", i + 1), got.spd[i], want.spd[i]);
                if (got.ph !== want.ph)
                    note_mismatch("gait_phase", got.ph, want.ph);
            end
        end
    end

    initial begin
        int st;
        // leg6 .. leg1 in each concatenation
        plan[0] = {{6{16'd0}}, 1'b1, CODE_4, {6{8'd0}}};
        plan[1] = {{16'd580, 16'd0, -16'sd220, 16'd0, 16'd220, 16'd0},
                   1'b1, CODE_1, {6{8'd0}}};
        plan[2] = {{16'd130, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'hffff},
                   1'b1, CODE_1, {8'd0, 8'd0, 8'd15, 8'd0, 8'd15, 8'd0}};
        plan[3] = {{16'd0, 16'd130, 16'd490, -16'sd130, 16'd130, 16'd130},
                   1'b1, CODE_2, {8'd15, {5{8'd0}}}};
        plan[4] = {{16'd220, 16'd0, 16'd220, 16'd1, 16'd220, -16'sd580},
                   1'b0, {RES_W{1'b0}}};
        plan[5] = {{16'd0, 16'd220, 16'd0, -16'sd940, 16'd0, 16'd359},
                   1'b0, {RES_W{1'b0}}};
        plan[6] = {{16'd0, 16'd130, 16'h8000, 16'd850, 16'h7fff, -16'sd130},
                   1'b0, {RES_W{1'b0}}};
        plan[7] = {{16'd360, -16'sd360, 16'h7fff, 16'h8000, 16'hffff, 16'd1},
                   1'b0, {RES_W{1'b0}}};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_PLAN; n++)
            offer_tick(plan[n].ang, plan[n].fixed, plan[n].res);

        for (int p = 0; p < N_CONFIGS; p++) begin
            burst = (p == 2 || p == 7);
            if (p > 0) begin
                wait_drained();
                repeat (4) @(posedge i_clk);
                case (p)
                    2: load_config(255, 0, 0, 359);
                    3: load_config(0, 255, 359, 0);
                    4: begin
                        st = $urandom_range(0, 359);
                        load_config($urandom_range(0, 255), $urandom_range(0, 255), st, st);
                    end
                    // targets past a full turn: legs can never finish
                    5: load_config($urandom_range(0, 255), $urandom_range(0, 255), 400,
                                   $urandom_range(0, 359));
                    6: load_config($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 359), 511);
                    default: load_config($urandom_range(0, 255), $urandom_range(0, 255),
                                         $urandom_range(0, 359), $urandom_range(0, 359));
                endcase
            end
            if (p == 2)
                rx_hold_req = 1'b1;
            for (int n = 0; n < N_TICKS; n++) begin
                if (p == 1 && n == N_TICKS / 2)
                    wait_drained();
                offer_tick(pick_tick(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_mismatch("results never delivered", pending_results.size(), 0);
        if (mismatches == 0)
            $display("angle_tripod_gait_sequencer: match");
        else
            $display("angle_tripod_gait_sequencer: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("angle_tripod_gait_sequencer: mismatch");
        $finish;
    end

endmodule
